@@ design/brms_pkg.sv @@
package brms_pkg;

  localparam int MAX_BLOCK  = 2048;
  localparam int CNT_W      = $clog2(MAX_BLOCK + 1);
  localparam int SAMPLE_W   = 16;
  localparam int SQ_W       = 2 * SAMPLE_W;
  localparam int SUM_W      = 42;
  localparam int GAIN_W     = 8;
  localparam int ROOT_W     = 16;
  localparam int SREM_W     = ROOT_W + 2;
  localparam int PROD_W     = GAIN_W + ROOT_W;
  localparam int LEVEL_W    = 16;
  localparam int DIV_STEPS  = SUM_W;
  localparam int SQRT_STEPS = ROOT_W;
  localparam int STEP_W     = $clog2(DIV_STEPS);

  localparam logic [CNT_W-1:0]  BLK_FULL   = CNT_W'(MAX_BLOCK);
  localparam logic [PROD_W-1:0] FULL_SCALE = PROD_W'(32768);
  localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(10);

  typedef enum logic [2:0] {
    ST_ACCUM,
    ST_FIN,
    ST_DIV,
    ST_SQRT,
    ST_MUL,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic acc;
    logic snap;
    logic div_step;
    logic sqrt_step;
    logic mul;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } sts_t;

endpackage

@@ design/block_rms_level_meter.sv @@
// Channel  Dir  Beat                      Sideband
// in_      in   sample (tdata[15:0])      tlast = last, tuser = silent
// out_     out  intensity (tdata[15:0])   tuser = overrun
// cfg_     in   gain (cfg_wdata[7:0])     write on cfg_we, no read-back
//
// Samples inside a block are taken one per cycle.
// At a block end in_tready is low while the sum is closed, the bit-serial divide and
// the root run, the multiply is done and the result waits to load into out_.
// A silent block end only closes the sum and gives no beat.
// out_ stalls only hold the finished result; the next block is accepted meanwhile,
// and the block end after it waits in the load state until the output frees.
// Reset (rst_n low, synchronous) clears the sums, the count and sets gain to 10.
module block_rms_level_meter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] sample
  input  logic        in_tlast,
  input  logic        in_tuser,   // [0] silent
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [15:0] intensity
  output logic        out_tuser,  // [0] overrun
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata
);
  import brms_pkg::*;

  cmd_t cmd;
  sts_t sts;

  brms_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_last   (in_tlast),
    .in_silent (in_tuser),
    .in_ready  (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  brms_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .sample    (in_tdata),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .intensity (out_tdata),
    .overrun   (out_tuser)
  );

endmodule

@@ design/brms_ctrl.sv @@
module brms_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_last,
  input  logic           in_silent,
  output logic           in_ready,
  input  brms_pkg::sts_t sts,
  output brms_pkg::cmd_t cmd
);
  import brms_pkg::*;

  localparam logic [STEP_W-1:0] DIV_LAST  = STEP_W'(DIV_STEPS - 1);
  localparam logic [STEP_W-1:0] SQRT_LAST = STEP_W'(SQRT_STEPS - 1);

  state_t              state_r, state_nxt;
  logic [STEP_W-1:0]   step_r, step_nxt;
  logic                silent_r, silent_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_ACCUM;
      step_r   <= '0;
      silent_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      step_r   <= step_nxt;
      silent_r <= silent_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    step_nxt   = step_r;
    silent_nxt = silent_r;
    in_ready   = 1'b0;
    cmd        = '0;
    unique case (state_r)
      ST_ACCUM: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.acc = 1'b1;
          if (in_last) begin
            silent_nxt = in_silent;
            state_nxt  = ST_FIN;
          end
        end
      end
      ST_FIN: begin
        // last square is folded into the snapshot through sum_tot; snapshot and clear
        cmd.snap  = 1'b1;
        step_nxt  = '0;
        state_nxt = silent_r ? ST_ACCUM : ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        step_nxt     = step_r + 1'b1;
        if (step_r == DIV_LAST) begin
          step_nxt  = '0;
          state_nxt = ST_SQRT;
        end
      end
      ST_SQRT: begin
        cmd.sqrt_step = 1'b1;
        step_nxt      = step_r + 1'b1;
        if (step_r == SQRT_LAST) begin
          step_nxt  = '0;
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_ACCUM;
        end
      end
      default: begin
        state_nxt = ST_ACCUM;
      end
    endcase
  end

endmodule

@@ design/brms_dp.sv @@
module brms_dp (
  input  logic                            clk,
  input  logic                            rst_n,
  input  brms_pkg::cmd_t                  cmd,
  output brms_pkg::sts_t                  sts,
  input  logic [brms_pkg::SAMPLE_W-1:0]   sample,
  input  logic                            cfg_we,
  input  logic [brms_pkg::GAIN_W-1:0]     cfg_wdata,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [brms_pkg::LEVEL_W-1:0]    intensity,
  output logic                            overrun
);
  import brms_pkg::*;

  logic [GAIN_W-1:0]   gain_r;

  logic [SAMPLE_W-1:0] mag;
  logic [SQ_W-1:0]     sq;
  logic [SQ_W-1:0]     sq_r;
  logic                sq_vld_r;
  logic [SUM_W-1:0]    sum_r, sum_tot;
  logic [CNT_W-1:0]    cnt_r;
  logic                ovr_r;

  logic [SUM_W-1:0]    quo_r;
  logic [CNT_W-1:0]    dvs_r;
  logic [CNT_W-1:0]    rem_r;
  logic [CNT_W:0]      dtmp, dsub;
  logic                dge;

  logic [SREM_W-1:0]   srem_r;
  logic [ROOT_W-1:0]   root_r;
  logic [SREM_W+1:0]   stmp, trial, ssub;
  logic                sge;

  logic [PROD_W-1:0]   prod_r;
  logic                ovr_snap_r;
  logic [LEVEL_W-1:0]  level;
  logic [LEVEL_W-1:0]  level_r;
  logic                out_ovr_r;
  logic                out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r <= GAIN_RESET;
    end else if (cfg_we) begin
      gain_r <= cfg_wdata;
    end
  end

  // |sample|; -32768 maps to 0x8000
  assign mag     = sample[SAMPLE_W-1] ? (~sample + 1'b1) : sample;
  assign sq      = mag * mag;
  assign sum_tot = sum_r + (sq_vld_r ? {{(SUM_W-SQ_W){1'b0}}, sq_r} : '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_vld_r <= 1'b0;
      sum_r    <= '0;
      cnt_r    <= '0;
      ovr_r    <= 1'b0;
    end else if (cmd.snap) begin
      sq_vld_r <= 1'b0;
      sum_r    <= '0;
      cnt_r    <= '0;
      ovr_r    <= 1'b0;
    end else begin
      sum_r    <= sum_tot;
      sq_vld_r <= 1'b0;
      if (cmd.acc) begin
        if (cnt_r < BLK_FULL) begin
          sq_vld_r <= 1'b1;
          cnt_r    <= cnt_r + 1'b1;
        end else begin
          ovr_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.acc) begin
      sq_r <= sq;
    end
  end

  // restoring divide, one quotient bit per beat of the step counter
  assign dtmp = {rem_r, quo_r[SUM_W-1]};
  assign dsub = dtmp - {1'b0, dvs_r};
  assign dge  = (dtmp >= {1'b0, dvs_r});

  // digit-by-digit root, quotient bits consumed two at a time from the top
  assign stmp  = {srem_r, quo_r[2*ROOT_W-1 -: 2]};
  assign trial = {2'b00, root_r, 2'b01};
  assign ssub  = stmp - trial;
  assign sge   = (stmp >= trial);

  always_ff @(posedge clk) begin
    if (cmd.snap) begin
      // empty count guard: dividing 0 by 1 yields a zero mean
      quo_r      <= (cnt_r == '0) ? '0 : sum_tot;
      dvs_r      <= (cnt_r == '0) ? CNT_W'(1) : cnt_r;
      rem_r      <= '0;
      srem_r     <= '0;
      root_r     <= '0;
      ovr_snap_r <= ovr_r;
    end else if (cmd.div_step) begin
      rem_r <= dge ? dsub[CNT_W-1:0] : dtmp[CNT_W-1:0];
      quo_r <= {quo_r[SUM_W-2:0], dge};
    end else if (cmd.sqrt_step) begin
      srem_r <= sge ? ssub[SREM_W-1:0] : stmp[SREM_W-1:0];
      root_r <= {root_r[ROOT_W-2:0], sge};
      quo_r  <= {quo_r[SUM_W-3:0], 2'b00};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod_r <= gain_r * root_r;
    end
  end

  assign level = (prod_r > FULL_SCALE) ? FULL_SCALE[LEVEL_W-1:0] : prod_r[LEVEL_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      level_r   <= level;
      out_ovr_r <= ovr_snap_r;
    end
  end

  assign sts.out_free = !out_valid_r || out_ready;
  assign out_valid    = out_valid_r;
  assign intensity    = level_r;
  assign overrun      = out_ovr_r;

endmodule

@@ design/brms_chk.sv @@
module brms_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        in_tlast,
  input logic        in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic        out_tuser
);

  // a waiting result holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("out beat changed while stalled");

  // level never exceeds 1.0
  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata <= 16'd32768)
    else $error("intensity above full scale");

  // every block end closes the sum, so in_tready is low in the cycle after it
  a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tlast |=> !in_tready)
    else $error("input taken right after block end");

  // a silent block end drops in_tready only while the sum closes, then resumes accepting
  a_silent_resume: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tlast && in_tuser |=> !in_tready ##1 in_tready)
    else $error("silent block end did not resume");

endmodule

bind block_rms_level_meter brms_chk u_brms_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tlast   (in_tlast),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
